>>> src/base64_stream_decoder_assert.svh
// Assertion macros for the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/b64d_pkg.sv
// Shared types, constants and the character lookup for the base64 stream decoder.
package b64d_pkg;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [5:0] SEXTET_NUM = 6'd52;
	localparam logic [5:0] SEXTET_LC  = 6'd26;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	// one queued job: up to six bytes, first byte in slot 5
	typedef struct packed {
		logic [5:0][7:0] bytes;
		logic [2:0]      count;
		logic            last;
		logic            empty;
	} b64d_entry_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] s;
		s = '0;
		case (c) inside
			[8'h41:8'h5A]: s = 6'(c - 8'h41);
			[8'h61:8'h7A]: s = SEXTET_LC + 6'(c - 8'h61);
			[8'h30:8'h39]: s = SEXTET_NUM + 6'(c - 8'h30);
			8'h2B:         s = SEXTET_PLUS;
			8'h2F:         s = SEXTET_SLASH;
			default:       s = '0;
		endcase
		return s;
	endfunction

endpackage

>>> src/b64d_front.sv
// Front end: takes characters, assembles groups, holds the newest group, builds byte jobs.
module b64d_front import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	input  logic        q_full,
	output logic        push,
	output b64d_entry_t entry
);

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic [23:0] held_q;
	logic        held_valid_q;
	logic        prev_pad_q;

	logic [5:0]  sextet;
	logic        is_pad;
	logic        accept;
	logic        complete;
	logic        flush;
	logic [23:0] held_next;
	logic        held_valid_next;
	logic [1:0]  pad_cnt;
	logic [2:0]  final_n;
	logic [23:0] final_group;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign sextet   = sextet_of(char_code);
	assign is_pad   = (char_code == CHAR_PAD);
	assign complete = (pos_q == 2'd3);
	assign flush    = complete && held_valid_q;

	assign held_next       = complete ? {acc_q, sextet} : held_q;
	assign held_valid_next = held_valid_q || complete;

	assign pad_cnt     = {1'b0, is_pad} + {1'b0, prev_pad_q};
	assign final_n     = held_valid_next ? (3'd3 - {1'b0, pad_cnt}) : 3'd1;
	assign final_group = held_valid_next ? held_next : 24'd0;

	always_comb begin
		entry.count = (flush ? 3'd3 : 3'd0) + (last_char ? final_n : 3'd0);
		entry.last  = last_char;
		entry.empty = last_char && !held_valid_next;
		if (flush) begin
			entry.bytes = {held_q, final_group};
		end else begin
			entry.bytes = {final_group, 24'd0};
		end
	end

	assign push = accept && (entry.count != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			pos_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			prev_pad_q   <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				// text done: start the next one clean
				acc_q        <= '0;
				pos_q        <= '0;
				held_q       <= '0;
				held_valid_q <= 1'b0;
				prev_pad_q   <= 1'b0;
			end else begin
				acc_q        <= complete ? 18'd0 : {acc_q[11:0], sextet};
				pos_q        <= pos_q + 2'd1;
				held_q       <= held_next;
				held_valid_q <= held_valid_next;
				prev_pad_q   <= is_pad;
			end
		end
	end

endmodule

>>> src/b64d_queue.sv
// Small flop-based FIFO of byte jobs between front and back.
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  b64d_entry_t                  push_entry,
	input  logic                         pop,
	output b64d_entry_t                  head,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule

>>> src/b64d_back.sv
// Back end: walks the head job one byte per word and retires it after its final byte.
module b64d_back import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  b64d_entry_t head,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        last_byte,
	output logic        stream_empty
);

	logic [2:0] idx_q;
	logic       at_end;
	logic       take;

	assign out_valid    = !q_empty;
	assign take         = out_valid && out_ready;
	assign at_end       = (idx_q == head.count - 3'd1);
	assign pop          = take && at_end;
	assign data_byte    = head.bytes[3'd5 - idx_q];
	assign last_byte    = head.last && at_end;
	assign stream_empty = head.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

>>> src/base64_stream_decoder.sv
// Base64 stream decoder: one character per word in, decoded bytes one per word out.
// Throughput: one character taken per cycle while the queue has room; one byte out per cycle while out_ready is high.
// Bytes of an item are written to the job queue on its accept edge and leave in order from the queue head.
// A complete group is held until the next group completes or the text ends (up to 6 bytes/item).
// Reset (arst_n low, async): group state, held group, queue pointers and byte index clear.
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       last_byte,
	output logic       stream_empty
);

	b64d_entry_t push_entry;
	b64d_entry_t head;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last_char (last_char),
		.q_full    (q_full),
		.push      (push),
		.entry     (push_entry)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty),
		.count      (q_count)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.stream_empty (stream_empty)
	);

	`B64D_ASSERT_NOW(a_empty_marker, out_valid && stream_empty, last_byte && (data_byte == 8'd0), "empty marker must be a final zero byte")
	`B64D_ASSERT_NOW(a_job_nonzero, out_valid, head.count != 3'd0, "queued job carries no bytes")
	`B64D_ASSERT_NOW(a_full_stalls, q_full, !in_ready, "input taken while job queue full")
	`B64D_ASSERT_NEXT(a_count_bound, 1'b1, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue count overflow")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for base64_stream_decoder: directed and random texts under handshake pressure.
module testbench import b64d_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEM_TARGET = 370;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} decoded_t;

	// Tracks the decoder state and queues the bytes each character should release.
	class b64_scoreboard;
		logic [17:0] partial;
		logic [1:0]  slot;
		logic [23:0] held;
		bit          held_ok;
		bit          prev_pad;
		decoded_t    expected_q[$];
		int unsigned mismatches;
		int unsigned compared;
		int unsigned empties;
		int unsigned texts;
		int unsigned chars;

		function new();
			clear_text();
		endfunction

		function void clear_text();
			partial  = '0;
			slot     = '0;
			held     = '0;
			held_ok  = 1'b0;
			prev_pad = 1'b0;
		endfunction

		function logic [5:0] char_value(input logic [7:0] c);
			if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
			if (c >= 8'h61 && c <= 8'h7A) return SEXTET_LC + 6'(c - 8'h61);
			if (c >= 8'h30 && c <= 8'h39) return SEXTET_NUM + 6'(c - 8'h30);
			if (c == 8'h2B) return SEXTET_PLUS;
			if (c == 8'h2F) return SEXTET_SLASH;
			return 6'd0;
		endfunction

		function void push_held(input int n, input bit mark_last);
			decoded_t e;
			for (int i = 0; i < n; i++) begin
				e.data  = 8'(held >> (16 - 8 * i));
				e.last  = mark_last && (i == n - 1);
				e.empty = 1'b0;
				expected_q.push_back(e);
			end
		endfunction

		function void note_char(input logic [7:0] c, input logic lc);
			logic [5:0] s;
			bit         pad;
			int         npad;
			decoded_t   e;
			s   = char_value(c);
			pad = (c == CHAR_PAD);
			chars++;
			if (slot == 2'd3) begin
				if (held_ok)
					push_held(3, 1'b0);
				held    = {partial, s};
				held_ok = 1'b1;
				partial = '0;
				slot    = '0;
			end else begin
				partial = {partial[11:0], s};
				slot    = slot + 2'd1;
			end
			if (lc) begin
				npad = int'(pad) + int'(prev_pad);
				if (held_ok) begin
					push_held(3 - npad, 1'b1);
				end else begin
					e.data  = 8'h00;
					e.last  = 1'b1;
					e.empty = 1'b1;
					expected_q.push_back(e);
				end
				texts++;
				clear_text();
			end else begin
				prev_pad = pad;
			end
		endfunction

		function void check_byte(input logic [7:0] data, input logic last, input logic empty);
			decoded_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("unexpected word: data %02h last %0b empty %0b", data, last, empty);
				return;
			end
			e = expected_q.pop_front();
			compared++;
			if (empty)
				empties++;
			if (e.data !== data || e.last !== last || e.empty !== empty) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT) begin
					$write("word mismatch: exp data %02h last %0b empty %0b, ",
						e.data, e.last, e.empty);
					$display("got data %02h last %0b empty %0b", data, last, empty);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_ready;
	logic [7:0] char_code    = 8'h00;
	logic       last_char    = 1'b0;
	logic       out_valid;
	logic       out_ready    = 1'b0;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       stream_empty;

	b64_scoreboard sb;
	int burst_left = 0;
	int gap_left   = 0;
	int chars_sent = 0;
	int stall_mode = 0;
	int stall_len  = 0;
	int stall_tick = 0;
	int cycles     = 0;

	base64_stream_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.last_char    (last_char),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.stream_empty (stream_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
			$display("base64_stream_decoder verification failed");
			$finish;
		end
	end

	// words are sampled before the edge updates anything
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_char(char_code, last_char);
			if (out_valid && out_ready)
				sb.check_byte(data_byte, last_byte, stream_empty);
		end
	end

	// receiver: modes of free flow, random stalls, sparse ready and long stalls
	always @(posedge clk) begin
		if (stall_len == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_len  = $urandom_range(16, 80);
		end
		stall_len--;
		stall_tick++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= (stall_tick % 3 == 0);
			default: out_ready <= (stall_tick % 16 >= 10);
		endcase
	end

	task automatic send_char(input logic [7:0] c, input logic lc);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= lc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		chars_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] b64_char(input int idx);
		if (idx < 26) return 8'h41 + 8'(idx);
		if (idx < 52) return 8'h61 + 8'(idx - 26);
		if (idx < 62) return 8'h30 + 8'(idx - 52);
		if (idx == 62) return 8'h2B;
		return 8'h2F;
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 3))
			0: return CHAR_PAD;
			1: return b64_char($urandom_range(0, 63));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly well-formed texts; some with a ragged tail, some pure noise
	task automatic send_random_text();
		int kind;
		int total;
		int pads;
		int tail;
		logic [7:0] c;
		kind = $urandom_range(0, 9);
		if (kind < 8) begin
			total = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
			total = 4 * total;
			pads  = $urandom_range(0, 2);
			tail  = (kind == 7) ? $urandom_range(1, 3) : 0;
			for (int i = 0; i < total + tail; i++) begin
				if (i >= total)
					c = noise_char();
				else if (i >= total - pads)
					c = CHAR_PAD;
				else
					c = b64_char($urandom_range(0, 63));
				send_char(c, i == total + tail - 1);
			end
		end else begin
			total = $urandom_range(1, 9);
			for (int i = 0; i < total; i++)
				send_char(noise_char(), i == total - 1);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_string("TWFu");
		send_string("QQ==");
		send_string("QUJD=");   // trailing pad in a partial group still counts
		send_string("=");
		send_string("A");
		send_string("T=Fu");    // pad mid-group decodes as zero
		// held group plus a group closing on the last char: six words
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_string("+/zaZ9");

		while (chars_sent < ITEM_TARGET)
			send_random_text();
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.mismatches++;
			$display("%0d expected words never arrived", sb.pending());
		end

		$display("%0d texts, %0d characters sent; %0d words compared, %0d empty markers",
			sb.texts, sb.chars, sb.compared, sb.empties);
		if (sb.mismatches > SHOW_LIMIT)
			$display("%0d mismatches in total", sb.mismatches);
		if (sb.mismatches == 0)
			$display("base64_stream_decoder verification clean");
		else
			$display("base64_stream_decoder verification failed");
		$finish;
	end

endmodule
